[src/bil_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_pkg: shared types and codes for the bounded indexed list
// Operation kinds, status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package bil_pkg;

  // Fixed field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LimitW  = 5;

  // Operation requested by one transfer
  typedef enum logic [KindW-1:0] {
    KIND_ADD_AT      = 3'd0,
    KIND_ADD_FIRST   = 3'd1,
    KIND_ADD_LAST    = 3'd2,
    KIND_REMOVE_AT   = 3'd3,
    KIND_REMOVE_LAST = 3'd4,
    KIND_GET_AT      = 3'd5,
    KIND_GET_LAST    = 3'd6,
    KIND_CLEAR       = 3'd7
  } kind_e;

  // Result status
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_MOVE  = 3'd1,
    S_DRAIN = 3'd2,
    S_PUT   = 3'd3,
    S_READ  = 3'd4,
    S_RESP  = 3'd5
  } state_e;

  // Register index of the limit register
  localparam int unsigned RegListLimit = 0;

endpackage

[src/bounded_indexed_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_indexed_list: ordered list of opaque entries with a set capacity
// Insert, remove, read and clear operations over an entry memory; entries
// are shifted one per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// One transfer on the slave stream is one operation; one result transfer
// follows on the master stream. The block takes a new operation only while
// its sequencer is idle. Inserts and removes shift the later entries one
// slot per cycle through the read and write ports of the entry memory.
// A remove that moves entries passes through accept, the moves, a last move
// write and the result load; an insert that moves entries also writes the
// new entry before the result load. The longest operation is an insert at
// the front of a list one short of its limit or an insert-first on a full
// list. Reads and inserts that move nothing add a read or a write step before
// the result load; other operations that move nothing go straight to it.
// A previous result still held in the output register delays the result
// load until it is taken. A finished result waits in the output register
// while the next operation is already accepted. The list_limit register
// (byte address 0) is written only while the list is empty; 0 is taken as 1
// and values above CAPACITY as CAPACITY.
// ----------------------------------------------------------------------------
module bounded_indexed_list #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned ENTRY_WIDTH = 40
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Operation stream
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata: position[4:0], entry_in[ENTRY_WIDTH+4:5], zero padding
  input  logic [((bil_pkg::PosW+ENTRY_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: kind[2:0]
  input  logic [bil_pkg::KindW-1:0] s_axis_tuser_i,

  // Result stream
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tdata: entry_out[ENTRY_WIDTH-1:0], occupancy above it, zero padding
  output logic [((ENTRY_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // tuser: status[1:0], read_valid[2]
  output logic [bil_pkg::StatusW:0] m_axis_tuser_o,

  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW     = (CntW > bil_pkg::PosW) ? CntW : bil_pkg::PosW;
  localparam int unsigned OutDataW = ((ENTRY_WIDTH + CntW + 7) / 8) * 8;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  bil_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  lim_q, lim_d;
  logic             pend_q, pend_d;
  logic             m_valid_q, m_valid_d;

  logic [AddrW-1:0]       src_q, src_d;
  logic [AddrW-1:0]       wa_q, wa_d;
  logic [CntW-1:0]        left_q, left_d;
  logic                   up_q, up_d;
  logic                   ins_q, ins_d;
  logic [AddrW-1:0]       iaddr_q, iaddr_d;
  logic [ENTRY_WIDTH-1:0] val_q, val_d;
  bil_pkg::status_e       st_q, st_d;
  logic                   rv_q, rv_d;
  bil_pkg::status_e       m_status_q, m_status_d;
  logic                   m_rv_q, m_rv_d;
  logic [ENTRY_WIDTH-1:0] m_entry_q, m_entry_d;
  logic [CntW-1:0]        m_occ_q, m_occ_d;

  // Entry memory, one read and one write port
  logic [ENTRY_WIDTH-1:0] mem_q [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rd_q;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_wa;
  logic [ENTRY_WIDTH-1:0] mem_wd;
  logic                   mem_re;
  logic [AddrW-1:0]       mem_ra;

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  bil_pkg::kind_e         in_kind;
  logic [bil_pkg::PosW-1:0] in_pos;
  logic [ENTRY_WIDTH-1:0] in_val;
  logic [CmpW-1:0]        pos_x, cnt_x;
  logic                   in_xfer;
  logic                   full;

  assign in_kind = bil_pkg::kind_e'(s_axis_tuser_i);
  assign in_pos  = s_axis_tdata_i[bil_pkg::PosW-1:0];
  assign in_val  = s_axis_tdata_i[bil_pkg::PosW +: ENTRY_WIDTH];
  assign pos_x   = CmpW'(in_pos);
  assign cnt_x   = CmpW'(cnt_q);
  assign full    = (cnt_q >= lim_q);

  assign s_axis_tready_o = (state_q == bil_pkg::S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Operation decode: status, new count and move plan
  // --------------------------------------------------------------------------
  bil_pkg::status_e dec_st;
  logic [CntW-1:0]  dec_cnt;
  logic [CntW-1:0]  dec_n;
  logic [AddrW-1:0] dec_src;
  logic             dec_up;
  logic             dec_ins;
  logic [AddrW-1:0] dec_iaddr;
  logic             dec_rd;

  always_comb begin
    dec_st    = bil_pkg::ST_OK;
    dec_cnt   = cnt_q;
    dec_n     = '0;
    dec_src   = '0;
    dec_up    = 1'b0;
    dec_ins   = 1'b0;
    dec_iaddr = '0;
    dec_rd    = 1'b0;
    case (in_kind)
      bil_pkg::KIND_ADD_AT: begin
        if (pos_x > cnt_x) begin
          dec_st = bil_pkg::ST_INVALID;
        end else if (full) begin
          dec_st = bil_pkg::ST_FULL;
        end else begin
          dec_ins   = 1'b1;
          dec_n     = CntW'(cnt_x - pos_x);
          dec_src   = AddrW'(cnt_q - 1'b1);
          dec_iaddr = AddrW'(in_pos);
          dec_cnt   = cnt_q + 1'b1;
        end
      end
      bil_pkg::KIND_ADD_FIRST: begin
        // on a full list the last entry falls off the end
        dec_ins = 1'b1;
        if (full) begin
          dec_n   = cnt_q - 1'b1;
          dec_src = AddrW'(cnt_q - CntW'(2));
        end else begin
          dec_n   = cnt_q;
          dec_src = AddrW'(cnt_q - 1'b1);
          dec_cnt = cnt_q + 1'b1;
        end
      end
      bil_pkg::KIND_ADD_LAST: begin
        if (full) begin
          dec_st = bil_pkg::ST_FULL;
        end else begin
          dec_ins   = 1'b1;
          dec_iaddr = AddrW'(cnt_q);
          dec_cnt   = cnt_q + 1'b1;
        end
      end
      bil_pkg::KIND_REMOVE_AT: begin
        if (cnt_q == '0) begin
          dec_st = bil_pkg::ST_EMPTY;
        end else if (pos_x < cnt_x) begin
          dec_n   = CntW'(cnt_x - pos_x - 1'b1);
          dec_src = AddrW'(pos_x + 1'b1);
          dec_up  = 1'b1;
          dec_cnt = cnt_q - 1'b1;
        end
      end
      bil_pkg::KIND_REMOVE_LAST: begin
        if (cnt_q == '0) begin
          dec_st = bil_pkg::ST_INVALID;
        end else begin
          dec_cnt = cnt_q - 1'b1;
        end
      end
      bil_pkg::KIND_GET_AT: begin
        if (pos_x < cnt_x) begin
          dec_rd  = 1'b1;
          dec_src = AddrW'(in_pos);
        end else begin
          dec_st = bil_pkg::ST_INVALID;
        end
      end
      bil_pkg::KIND_GET_LAST: begin
        if (cnt_q != '0) begin
          dec_rd  = 1'b1;
          dec_src = AddrW'(cnt_q - 1'b1);
        end else begin
          dec_st = bil_pkg::ST_INVALID;
        end
      end
      bil_pkg::KIND_CLEAR: begin
        dec_cnt = '0;
      end
      default: begin
        dec_cnt = cnt_q;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Configuration write
  // --------------------------------------------------------------------------
  logic                       cfg_wr;
  logic [bil_pkg::LimitW-1:0] cfg_v;
  logic [CmpW-1:0]            cfg_vx;
  logic [CntW-1:0]            cfg_lim;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == 1'(bil_pkg::RegListLimit)) && (cnt_q == '0);
  assign cfg_v  = pwdata[bil_pkg::LimitW-1:0];
  assign cfg_vx = CmpW'(cfg_v);

  always_comb begin
    if (cfg_v == '0) begin
      cfg_lim = CntW'(1);
    end else if (cfg_vx > CmpW'(CAPACITY)) begin
      cfg_lim = CntW'(CAPACITY);
    end else begin
      cfg_lim = CntW'(cfg_vx);
    end
  end

  assign prdata = (paddr[2] == 1'(bil_pkg::RegListLimit)) ? 32'(lim_q) : '0;

  // --------------------------------------------------------------------------
  // Sequencer: next state, memory control and register updates
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    lim_d      = cfg_wr ? cfg_lim : lim_q;
    pend_d     = pend_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    src_d      = src_q;
    wa_d       = wa_q;
    left_d     = left_q;
    up_d       = up_q;
    ins_d      = ins_q;
    iaddr_d    = iaddr_q;
    val_d      = val_q;
    st_d       = st_q;
    rv_d       = rv_q;
    m_status_d = m_status_q;
    m_rv_d     = m_rv_q;
    m_entry_d  = m_entry_q;
    m_occ_d    = m_occ_q;
    mem_we     = 1'b0;
    mem_wa     = wa_q;
    mem_wd     = rd_q;
    mem_re     = 1'b0;
    mem_ra     = src_q;
    case (state_q)
      bil_pkg::S_IDLE: begin
        if (in_xfer) begin
          cnt_d   = dec_cnt;
          st_d    = dec_st;
          rv_d    = dec_rd;
          src_d   = dec_src;
          left_d  = dec_n;
          up_d    = dec_up;
          ins_d   = dec_ins;
          iaddr_d = dec_iaddr;
          val_d   = in_val;
          pend_d  = 1'b0;
          if (dec_n != '0) begin
            state_d = bil_pkg::S_MOVE;
          end else if (dec_ins) begin
            state_d = bil_pkg::S_PUT;
          end else if (dec_rd) begin
            state_d = bil_pkg::S_READ;
          end else begin
            state_d = bil_pkg::S_RESP;
          end
        end
      end
      bil_pkg::S_MOVE: begin
        // write the entry fetched last cycle, fetch the next one
        mem_we = pend_q;
        mem_re = 1'b1;
        pend_d = 1'b1;
        wa_d   = up_q ? (src_q - 1'b1) : (src_q + 1'b1);
        src_d  = up_q ? (src_q + 1'b1) : (src_q - 1'b1);
        left_d = left_q - 1'b1;
        if (left_q == CntW'(1)) begin
          state_d = bil_pkg::S_DRAIN;
        end
      end
      bil_pkg::S_DRAIN: begin
        mem_we  = 1'b1;
        pend_d  = 1'b0;
        state_d = ins_q ? bil_pkg::S_PUT : bil_pkg::S_RESP;
      end
      bil_pkg::S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = iaddr_q;
        mem_wd  = val_q;
        state_d = bil_pkg::S_RESP;
      end
      bil_pkg::S_READ: begin
        mem_re  = 1'b1;
        state_d = bil_pkg::S_RESP;
      end
      bil_pkg::S_RESP: begin
        // load the output register once the previous result is taken
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = st_q;
          m_rv_d     = rv_q;
          m_entry_d  = rv_q ? rd_q : '0;
          m_occ_d    = cnt_q;
          state_d    = bil_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bil_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bil_pkg::S_IDLE;
      cnt_q     <= '0;
      lim_q     <= CntW'(CAPACITY);
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      lim_q     <= lim_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    wa_q       <= wa_d;
    left_q     <= left_d;
    up_q       <= up_d;
    ins_q      <= ins_d;
    iaddr_q    <= iaddr_d;
    val_q      <= val_d;
    st_q       <= st_d;
    rv_q       <= rv_d;
    m_status_q <= m_status_d;
    m_rv_q     <= m_rv_d;
    m_entry_q  <= m_entry_d;
    m_occ_q    <= m_occ_d;
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutDataW'({m_occ_q, m_entry_q});
  assign m_axis_tuser_o  = {m_rv_q, m_status_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // occupancy never exceeds the limit in use
  a_cnt_le_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lim_q)
    else $error("entry count above list limit");

  // limit stays in its legal range
  a_lim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lim_q != '0) && (lim_q <= CntW'(CAPACITY)))
    else $error("list limit out of range");

  // an accepted operation closes the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("input accepted while an operation is in flight");

  // the shift loop always has a move left while in the move state
  a_move_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bil_pkg::S_MOVE) |-> (left_q != '0))
    else $error("move state with no moves left");

  // a read result carries a success status
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_rv_q) |-> (m_status_q == bil_pkg::ST_OK))
    else $error("read result with failing status");
`endif

endmodule
